@@ rtl/core/qslp_pkg.sv @@
// ----------------------------------------------------------------------------
// qslp_pkg
// Shared types, constants and the arctangent table generator for the
// quaternion slerp block.
// ----------------------------------------------------------------------------
package qslp_pkg;

  localparam int unsigned CompW   = 18;
  localparam int unsigned NegW    = 19;
  localparam int unsigned FactW   = 17;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned ProdW   = 36;
  localparam int unsigned DotW    = 38;
  localparam int unsigned DotFrac = 32;
  localparam int unsigned LinFrac = 16;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QLvlW   = $clog2(QDepth + 1);

  localparam logic [FactW-1:0] FactOne = 17'd65536;
  localparam logic [ThrW-1:0]  ThrRst  = 16'd7;
  localparam int               SatMax  = 131071;
  localparam int               SatMin  = -131072;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [NegW-1:0]  ecomp_t;

  typedef struct packed {
    comp_t  [3:0]     st;
    ecomp_t [3:0]     en;
    logic [FactW-1:0] fact;
    logic             lin;
  } item_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QLvlW-1:0] level;
  } q_stat_t;

  // atan(2^-idx) in Q.frac, rounded to nearest
  function automatic longint unsigned atan_entry(int unsigned idx, int unsigned frac);
    longint unsigned acc;
    longint unsigned term;
    longint unsigned odd;
    longint unsigned rem;
    int              expn;
    acc = 64'd0;
    if (idx == 0) begin
      acc = 64'h3243_F6A8_885A_308D;
    end else begin
      for (int unsigned k = 0; k < 64; k++) begin
        odd  = longint'(2 * k + 1);
        expn = 62 - int'(idx * (2 * k + 1));
        if (expn >= 0) begin
          // long division of 2^expn by the odd term index
          term = 64'd0;
          rem  = 64'd0;
          for (int b = 63; b >= 0; b--) begin
            rem  = {rem[62:0], (b == expn)};
            term = {term[62:0], 1'b0};
            if (rem >= odd) begin
              rem     = rem - odd;
              term[0] = 1'b1;
            end
          end
          if (k[0]) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
    end
    return (acc + (64'd1 << (61 - frac))) >> (62 - frac);
  endfunction

endpackage

@@ rtl/core/qslp_cordic.sv @@
// ----------------------------------------------------------------------------
// qslp_cordic
// Pipelined CORDIC, one iteration per stage; vectoring mode returns the
// angle, rotation mode returns the sine component.
// ----------------------------------------------------------------------------
module qslp_cordic
  import qslp_pkg::*;
#(
  parameter int unsigned Width  = 19,
  parameter int unsigned Steps  = 16,
  parameter int unsigned Frac   = 16,
  parameter bit          Vector = 1'b0
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [Width-1:0] x_i,
  input  logic signed [Width-1:0] y_i,
  input  logic signed [Width-1:0] z_i,
  output logic signed [Width-1:0] res_o
);

  logic signed [Width-1:0] x_q [Steps];
  logic signed [Width-1:0] y_q [Steps];
  logic signed [Width-1:0] z_q [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [Width-1:0] Ang = Width'(atan_entry(i, Frac));
    logic signed [Width-1:0] xc, yc, zc, dx, dy;
    logic                    ccw;
    if (i == 0) begin : g_first
      assign xc = x_i;
      assign yc = y_i;
      assign zc = z_i;
    end else begin : g_next
      assign xc = x_q[i-1];
      assign yc = y_q[i-1];
      assign zc = z_q[i-1];
    end
    assign dx  = xc >>> i;
    assign dy  = yc >>> i;
    assign ccw = Vector ? yc[Width-1] : ~zc[Width-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ccw) begin
          x_q[i] <= xc - dy;
          y_q[i] <= yc + dx;
          z_q[i] <= zc - Ang;
        end else begin
          x_q[i] <= xc + dy;
          y_q[i] <= yc - dx;
          z_q[i] <= zc + Ang;
        end
      end
    end
  end

  assign res_o = Vector ? z_q[Steps-1] : y_q[Steps-1];

endmodule

@@ rtl/core/qslp_div.sv @@
// ----------------------------------------------------------------------------
// qslp_div
// Pipelined restoring divider for the spherical weights: (num << Frac) / den,
// zero for a non-positive numerator, clamped to 1.0.
// ----------------------------------------------------------------------------
module qslp_div
  import qslp_pkg::*;
#(
  parameter int unsigned Frac  = 16,
  parameter int unsigned Width = 19
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [Width-1:0] num_i,
  input  logic signed [Width-1:0] den_i,
  output logic [Frac:0]           quo_o
);

  localparam logic [Frac:0] QOne = {1'b1, {Frac{1'b0}}};

  logic [Width-1:0] num_u, den_u, twice;
  logic [Width-1:0] rem_q  [Frac+1];
  logic [Width-1:0] den_q  [Frac+1];
  logic [Frac-1:0]  bits_q [Frac+1];
  logic             zero_q [Frac+1];
  logic             ovf_q  [Frac+1];
  logic             hi_q   [Frac+1];

  assign num_u = num_i;
  assign den_u = den_i;
  assign twice = {den_u[Width-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= num_i[Width-1] | (num_i == '0);
      ovf_q[0]  <= num_u >= twice;
      hi_q[0]   <= num_u >= den_u;
      rem_q[0]  <= (num_u >= den_u) ? num_u - den_u : num_u;
      den_q[0]  <= den_u;
      bits_q[0] <= '0;
    end
  end

  for (genvar j = 1; j <= Frac; j++) begin : g_step
    logic [Width-1:0] rem2;
    logic             qbit;
    assign rem2 = {rem_q[j-1][Width-2:0], 1'b0};
    assign qbit = rem2 >= den_q[j-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= qbit ? rem2 - den_q[j-1] : rem2;
        den_q[j]  <= den_q[j-1];
        bits_q[j] <= {bits_q[j-1][Frac-2:0], qbit};
        zero_q[j] <= zero_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        hi_q[j]   <= hi_q[j-1];
      end
    end
  end

  always_comb begin
    if (zero_q[Frac]) begin
      quo_o = '0;
    end else if (ovf_q[Frac] || (hi_q[Frac] && (bits_q[Frac] != '0))) begin
      quo_o = QOne;
    end else begin
      quo_o = {hi_q[Frac], bits_q[Frac]};
    end
  end

endmodule

@@ rtl/core/qslp_front.sv @@
// ----------------------------------------------------------------------------
// qslp_front
// Input stages: dot product, shorter-arc flip, path classification and the
// radicand for the sine of the angle.
// ----------------------------------------------------------------------------
module qslp_front
  import qslp_pkg::*;
#(
  parameter int unsigned Frac = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  comp_t [3:0]        st_i,
  input  comp_t [3:0]        en_i,
  input  logic [FactW-1:0]   fact_i,
  input  logic [ThrW-1:0]    thr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output item_t              item_o,
  output logic [Frac-1:0]    c_o,
  output logic [2*Frac:0]    r_o
);

  localparam logic signed [DotW:0] OneQ = (DotW + 1)'(64'd1 << DotFrac);
  localparam logic [2*Frac:0]      ROne = {1'b1, {(2 * Frac){1'b0}}};

  logic [3:0] v_q;
  logic       adv;

  logic signed [ProdW-1:0] pr_q [4];
  comp_t [3:0]             st1_q, en1_q, st2_q, en2_q;
  logic [FactW-1:0]        f1_q, f2_q;
  logic signed [DotW-1:0]  dot_q, dot_d;

  item_t            it3_q, it4_q;
  logic [DotW-1:0]  dabs_q, dabs;
  logic             neg;
  logic signed [DotW:0] om, thr_ext;
  logic [Frac-1:0]  c;
  logic [2*Frac-1:0] sq;
  logic [Frac-1:0]  c_q;
  logic [2*Frac:0]  r_q;

  assign adv        = ~v_q[3] | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[2:0], in_valid_i};
    end
  end

  assign dot_d = pr_q[0] + pr_q[1] + pr_q[2] + pr_q[3];

  assign neg     = dot_q[DotW-1];
  assign dabs    = neg ? DotW'(-dot_q) : DotW'(dot_q);
  assign thr_ext = {{(DotW + 1 - ThrW - LinFrac){1'b0}}, thr_i, {LinFrac{1'b0}}};
  assign om      = OneQ - $signed({1'b0, dabs});

  assign c  = dabs_q[DotFrac-1 -: Frac];
  assign sq = c * c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pr_q[i] <= st_i[i] * en_i[i];
      end
      st1_q <= st_i;
      en1_q <= en_i;
      f1_q  <= (fact_i > FactOne) ? FactOne : fact_i;

      dot_q <= dot_d;
      st2_q <= st1_q;
      en2_q <= en1_q;
      f2_q  <= f1_q;

      dabs_q <= dabs;
      for (int i = 0; i < 4; i++) begin
        it3_q.st[i] <= st2_q[i];
        it3_q.en[i] <= neg ? -NegW'($signed(en2_q[i])) : NegW'($signed(en2_q[i]));
      end
      it3_q.fact <= f2_q;
      it3_q.lin  <= ~(om > thr_ext);

      it4_q <= it3_q;
      c_q   <= c;
      r_q   <= ROne - {1'b0, sq};
    end
  end

  assign out_valid_o = v_q[3];
  assign item_o      = it4_q;
  assign c_o         = c_q;
  assign r_o         = r_q;

endmodule

@@ rtl/core/qslp_fifo.sv @@
// ----------------------------------------------------------------------------
// qslp_fifo
// Short queue between front and back; each side stalls on its own.
// ----------------------------------------------------------------------------
module qslp_fifo
  import qslp_pkg::*;
#(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] data_o,
  output q_stat_t          stat_o
);

  logic [Width-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QLvlW-1:0] cnt_q;
  logic             push, pop, full, empty;

  assign full  = cnt_q == QLvlW'(QDepth);
  assign empty = cnt_q == '0;
  assign push  = in_valid_i & ~full;
  assign pop   = out_ready_i & ~empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign in_ready_o   = ~full;
  assign out_valid_o  = ~empty;
  assign data_o       = mem_q[rd_q];
  assign stat_o.full  = full;
  assign stat_o.empty = empty;
  assign stat_o.level = cnt_q;

endmodule

@@ rtl/core/qslp_back.sv @@
// ----------------------------------------------------------------------------
// qslp_back
// Execution pipeline: square root, angle, sines, weight division and the
// weighted sum with rounding and saturation.
// ----------------------------------------------------------------------------
module qslp_back
  import qslp_pkg::*;
#(
  parameter int unsigned Frac  = 16,
  parameter int unsigned Steps = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  item_t           item_i,
  input  logic [Frac-1:0] c_i,
  input  logic [2*Frac:0] r_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output comp_t [3:0]     out_comp_o,
  output logic            out_lin_o
);

  localparam int unsigned Width  = Frac + 3;
  localparam int unsigned SqSt   = Frac + 1;
  localparam int unsigned RtW    = Frac + 1;
  localparam int unsigned RemW   = 2 * Frac + 3;
  localparam int unsigned ItmDly = SqSt + 2 * Steps + Frac + 2;
  localparam int unsigned Lat    = ItmDly + 2;
  localparam int unsigned WgtW   = (Frac + 1 > FactW) ? Frac + 1 : FactW;
  localparam int unsigned PrW    = WgtW + NegW + 1;
  localparam int unsigned AccW   = PrW + 1;

  localparam logic signed [Width-1:0] XOne    = Width'(1) << Frac;
  localparam logic signed [AccW-1:0]  LinHalf = AccW'(1) << (LinFrac - 1);
  localparam logic signed [AccW-1:0]  SphHalf = AccW'(1) << (Frac - 1);
  localparam logic signed [AccW-1:0]  SatHi   = AccW'(SatMax);
  localparam logic signed [AccW-1:0]  SatLo   = AccW'(SatMin);

  logic [Lat-1:0] v_q;
  logic           adv;

  assign adv        = ~v_q[Lat-1] | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Lat-2:0], in_valid_i};
    end
  end

  item_t           itm_q [ItmDly];
  logic [Frac-1:0] c_q   [SqSt];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      itm_q[0] <= item_i;
      c_q[0]   <= c_i;
      for (int k = 1; k < ItmDly; k++) begin
        itm_q[k] <= itm_q[k-1];
      end
      for (int k = 1; k < SqSt; k++) begin
        c_q[k] <= c_q[k-1];
      end
    end
  end

  logic [RemW-1:0] rm_q [SqSt];
  logic [RtW-1:0]  rt_q [SqSt];

  for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
    localparam int unsigned B = Frac - k;
    logic [RemW-1:0] rmc, trial;
    logic [RtW-1:0]  rtc;
    if (k == 0) begin : g_first
      assign rmc = RemW'(r_i);
      assign rtc = '0;
    end else begin : g_next
      assign rmc = rm_q[k-1];
      assign rtc = rt_q[k-1];
    end
    assign trial = (RemW'(rtc) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rmc >= trial) begin
          rm_q[k] <= rmc - trial;
          rt_q[k] <= rtc | (RtW'(1) << B);
        end else begin
          rm_q[k] <= rmc;
          rt_q[k] <= rtc;
        end
      end
    end
  end

  logic signed [Width-1:0] omega;

  qslp_cordic #(
    .Width  (Width),
    .Steps  (Steps),
    .Frac   (Frac),
    .Vector (1'b1)
  ) u_angle (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (Width'(c_q[SqSt-1])),
    .y_i   (Width'(rt_q[SqSt-1])),
    .z_i   ('0),
    .res_o (omega)
  );

  logic [FactW-1:0]            fact_a;
  logic signed [Width+FactW:0] mp, mq;
  logic signed [Width-1:0]     om_q, ap_q, aq_q;

  assign fact_a = itm_q[SqSt+Steps-1].fact;
  assign mp     = $signed({1'b0, FactOne - fact_a}) * omega;
  assign mq     = $signed({1'b0, fact_a}) * omega;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      om_q <= omega;
      ap_q <= Width'(mp >>> LinFrac);
      aq_q <= Width'(mq >>> LinFrac);
    end
  end

  logic signed [Width-1:0] sinom, sinp, sinq;

  qslp_cordic #(.Width(Width), .Steps(Steps), .Frac(Frac), .Vector(1'b0)) u_sin_om (
    .clk_i (clk_i), .en_i (adv), .x_i (XOne), .y_i ('0), .z_i (om_q), .res_o (sinom)
  );
  qslp_cordic #(.Width(Width), .Steps(Steps), .Frac(Frac), .Vector(1'b0)) u_sin_p (
    .clk_i (clk_i), .en_i (adv), .x_i (XOne), .y_i ('0), .z_i (ap_q), .res_o (sinp)
  );
  qslp_cordic #(.Width(Width), .Steps(Steps), .Frac(Frac), .Vector(1'b0)) u_sin_q (
    .clk_i (clk_i), .en_i (adv), .x_i (XOne), .y_i ('0), .z_i (aq_q), .res_o (sinq)
  );

  logic [Frac:0] wps, wqs, pos_q;

  qslp_div #(.Frac(Frac), .Width(Width)) u_div_p (
    .clk_i (clk_i), .en_i (adv), .num_i (sinp), .den_i (sinom), .quo_o (wps)
  );
  qslp_div #(.Frac(Frac), .Width(Width)) u_div_q (
    .clk_i (clk_i), .en_i (adv), .num_i (sinq), .den_i (sinom), .quo_o (wqs)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q <= {pos_q[Frac-1:0], ~sinom[Width-1] & (sinom != '0)};
    end
  end

  item_t                  it;
  logic                   lin;
  logic [WgtW-1:0]        wp, wq;
  logic signed [PrW-1:0]  pp_d [4];
  logic signed [PrW-1:0]  pq_d [4];
  logic signed [PrW-1:0]  pp_q [4];
  logic signed [PrW-1:0]  pq_q [4];
  logic                   lin_q;

  assign it  = itm_q[ItmDly-1];
  assign lin = it.lin | ~pos_q[Frac];
  assign wp  = lin ? WgtW'(FactOne - it.fact) : WgtW'(wps);
  assign wq  = lin ? WgtW'(it.fact) : WgtW'(wqs);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pp_d[i] = $signed({1'b0, wp}) * $signed(it.st[i]);
      pq_d[i] = $signed({1'b0, wq}) * $signed(it.en[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q  <= pp_d;
      pq_q  <= pq_d;
      lin_q <= lin;
    end
  end

  logic signed [AccW-1:0] acc [4];
  logic signed [AccW-1:0] rnd [4];
  comp_t                  res [4];
  comp_t                  out_q [4];
  logic                   lin_out_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      acc[i] = pp_q[i] + pq_q[i];
      rnd[i] = lin_q ? (acc[i] + LinHalf) >>> LinFrac : (acc[i] + SphHalf) >>> Frac;
      if (rnd[i] > SatHi) begin
        res[i] = CompW'(SatHi);
      end else if (rnd[i] < SatLo) begin
        res[i] = CompW'(SatLo);
      end else begin
        res[i] = CompW'(rnd[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q     <= res;
      lin_out_q <= lin_q;
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_out
    assign out_comp_o[i] = out_q[i];
  end

  assign out_valid_o = v_q[Lat-1];
  assign out_lin_o   = lin_out_q;

endmodule

@@ rtl/core/quaternion_slerp.sv @@
// ----------------------------------------------------------------------------
// quaternion_slerp
// Pipelines: square root, angle, sine and divider, one iteration per stage.
// Throughput: one transfer per cycle on each side while back-pressure does
//   not stall it; a four-entry queue sits between the input stages and the
//   execution pipeline.
// Reset: asynchronous, active low; clears all valid state, near_threshold = 7.
// ----------------------------------------------------------------------------
module quaternion_slerp
  import qslp_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = 16,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,   // near_threshold
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w,
  // blend_factor, zero pad
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic [0:0]   m_axis_tuser   // used_linear
);

  localparam int unsigned QW = $bits(item_t) + 3 * FRAC_BITS + 1;

  logic [ThrW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrRst;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  comp_t [3:0] st, en;
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign st[i] = s_axis_tdata[i*CompW +: CompW];
    assign en[i] = s_axis_tdata[(4+i)*CompW +: CompW];
  end

  logic                 f_valid, f_ready;
  item_t                f_item, b_item;
  logic [FRAC_BITS-1:0] f_c, b_c;
  logic [2*FRAC_BITS:0] f_r, b_r;
  logic [QW-1:0]        b_data;
  logic                 b_valid, b_ready;
  q_stat_t              q_stat;
  comp_t [3:0]          res;
  logic                 res_lin;

  qslp_front #(.Frac(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .st_i        (st),
    .en_i        (en),
    .fact_i      (s_axis_tdata[8*CompW +: FactW]),
    .thr_i       (thr_q),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .item_o      (f_item),
    .c_o         (f_c),
    .r_o         (f_r)
  );

  qslp_fifo #(.Width(QW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .data_i      ({f_item, f_c, f_r}),
    .out_valid_o (b_valid),
    .out_ready_i (b_ready),
    .data_o      (b_data),
    .stat_o      (q_stat)
  );

  assign {b_item, b_c, b_r} = b_data;

  qslp_back #(.Frac(FRAC_BITS), .Steps(CORDIC_STEPS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid),
    .in_ready_o  (b_ready),
    .item_i      (b_item),
    .c_i         (b_c),
    .r_i         (b_r),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_comp_o  (res),
    .out_lin_o   (res_lin)
  );

  assign m_axis_tdata = {res[3], res[2], res[1], res[0]};
  assign m_axis_tuser = res_lin;

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_stat.full)
    else $error("front stalled while queue has room");

  a_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.level <= QLvlW'(QDepth))
    else $error("queue level beyond depth");

  a_full_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

endmodule
